// ----- rtl/core/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg - text console character writer package
// Shared constants, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // Default screen geometry
   localparam int COLUMNS_DEFAULT    = 80;
   localparam int ROWS_COUNT_DEFAULT = 25;

   // Field widths of the request, response and attribute ports
   localparam int CODE_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   // Cell and attribute constants
   localparam logic [CELL_W-1:0] BLANK_RESET = 16'h1720;
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd23;

   // Character codes
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_LINE_FEED = 8'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN    = 8'd13;
   localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

   // Request kinds
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_RESPOND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;         // capture request fields
      logic clear_wr;      // write one blank cell of the clearing pass
      logic issue_read;    // start a cell read for a read request
      logic capture_read;  // take read data into the response register
      logic apply_put;     // update cursor and write the put cell
      logic sweep_clr;     // restart the sweep counter
      logic copy_step;     // one step of the scroll copy
      logic fill_step;     // one step of the bottom row fill
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;    // last cell of the clearing pass
      logic is_read;       // latched request is a read
      logic need_scroll;   // current put runs past the last cell
      logic copy_last;     // last step of the scroll copy
      logic fill_last;     // last step of the bottom row fill
   } status_type;

endpackage

// ----- rtl/core/text_console_character_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_character_writer - character-cell text console
// Screen store of COLUMNS x ROWS_COUNT attributed cells with a linear cursor.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. A put
// (req_type 0) prints req_char_code at the cursor or handles backspace,
// line feed or carriage return; a read returns the cell at req_cell_index
// (zero when out of range). Each request gives one response, shown for one
// cycle with rsp_valid high; the receiver cannot stall and must take it then.
// csr_wr_en/csr_wr_data write the color attribute; the user must write it
// only while idle, as the block itself does not enforce this. A put strobes
// its response after the decode state, a read after the registered store
// read and the capture. The next request can be taken in the cycle after the
// strobe. A put that scrolls copies the store one cell a cycle through its
// single write port, then fills the bottom row. Reset puts the cursor at 0
// and the attribute at 0x17; a clearing pass then writes blank cells, with
// busy high throughout.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
   parameter int COLUMNS    = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS_COUNT = tccw_pkg::ROWS_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [tccw_pkg::CODE_W-1:0]     req_char_code,
   input  logic [tccw_pkg::INDEX_W-1:0]    req_cell_index,
   output logic                            rsp_valid,
   output logic [tccw_pkg::CELL_W-1:0]     rsp_cell_value,
   output logic [tccw_pkg::INDEX_W-1:0]    rsp_cursor_position,
   output logic                            rsp_scrolled,
   input  logic                            csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]     csr_wr_data
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   // Controller
   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath
   tccw_dpath #(
      .COLUMNS    (COLUMNS),
      .ROWS_COUNT (ROWS_COUNT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_type            (req_type),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled)
   );

endmodule

// ----- rtl/core/tccw_ram.sv -----
// ----------------------------------------------------------------------------
// tccw_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccw_ctrl - console writer controller
// Sequences clearing, request decode, reads, scrolls and the response strobe.
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tccw_pkg::status_type  status,
   output tccw_pkg::cmd_type     cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   tccw_pkg::state_type state_ff;
   tccw_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         tccw_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         tccw_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = tccw_pkg::ST_DECODE;
            end
         end
         tccw_pkg::ST_DECODE: begin
            if (status.is_read) begin
               cmd.issue_read = 1'b1;
               state_in       = tccw_pkg::ST_READ;
            end else begin
               cmd.apply_put = 1'b1;
               if (status.need_scroll) begin
                  cmd.sweep_clr = 1'b1;
                  state_in      = tccw_pkg::ST_COPY;
               end else begin
                  state_in = tccw_pkg::ST_RESPOND;
               end
            end
         end
         tccw_pkg::ST_READ: begin
            cmd.capture_read = 1'b1;
            state_in         = tccw_pkg::ST_RESPOND;
         end
         tccw_pkg::ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) begin
               state_in = tccw_pkg::ST_FILL;
            end
         end
         tccw_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = tccw_pkg::ST_RESPOND;
            end
         end
         tccw_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = tccw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/tccw_dpath.sv -----
// ----------------------------------------------------------------------------
// tccw_dpath - console writer datapath
// Screen store, cursor registers, sweep counter and response registers.
// ----------------------------------------------------------------------------
module tccw_dpath #(
   parameter int COLUMNS    = tccw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS_COUNT = tccw_pkg::ROWS_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tccw_pkg::cmd_type               cmd,
   output tccw_pkg::status_type            status,
   input  logic                            csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]     csr_wr_data,
   input  logic                            req_type,
   input  logic [tccw_pkg::CODE_W-1:0]     req_char_code,
   input  logic [tccw_pkg::INDEX_W-1:0]    req_cell_index,
   output logic [tccw_pkg::CELL_W-1:0]     rsp_cell_value,
   output logic [tccw_pkg::INDEX_W-1:0]    rsp_cursor_position,
   output logic                            rsp_scrolled
);

   localparam int CELLS = COLUMNS * ROWS_COUNT;
   localparam int AW    = $clog2(CELLS);       // cell address
   localparam int SW    = $clog2(CELLS + 1);   // sweep counter
   localparam int CW    = $clog2(COLUMNS);     // column
   localparam int RW    = $clog2(ROWS_COUNT + 1);
   localparam int LW    = AW + 1;              // linear cursor before scroll fixup

   // Configuration register
   logic [tccw_pkg::ATTR_W-1:0] attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccw_pkg::ATTR_RESET;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   // Latched request
   logic                         type_ff;
   logic [tccw_pkg::CODE_W-1:0]  code_ff;
   logic [tccw_pkg::INDEX_W-1:0] index_ff;
   logic                         in_range_ff;
   logic                         in_range;

   assign in_range = 32'(index_ff) < 32'(CELLS);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff  <= req_type;
         code_ff  <= req_char_code;
         index_ff <= req_cell_index;
      end
      if (cmd.issue_read) begin
         in_range_ff <= in_range;
      end
   end

   // Cursor kept as row, column and linear position
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] lin_ff, lin_in;
   logic [RW-1:0] row_nx;
   logic [LW-1:0] lin_nx;
   logic          printable;
   logic          need_scroll;

   always_comb begin
      row_nx    = row_ff;
      col_in    = col_ff;
      lin_nx    = LW'(lin_ff);
      printable = 1'b0;
      case (code_ff)
         tccw_pkg::CODE_BACKSPACE: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
               lin_nx = LW'(lin_ff) - 1'b1;
            end
         end
         tccw_pkg::CODE_LINE_FEED: begin
            row_nx = row_ff + 1'b1;
            lin_nx = LW'(lin_ff) + LW'(COLUMNS);
         end
         tccw_pkg::CODE_RETURN: begin
            col_in = '0;
            lin_nx = LW'(lin_ff) - LW'(col_ff);
         end
         default: begin
            printable = 1'b1;
            lin_nx    = LW'(lin_ff) + 1'b1;
            if (col_ff == CW'(COLUMNS - 1)) begin
               col_in = '0;
               row_nx = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      endcase
      // Past the last row: scroll and pull the cursor back up one row
      need_scroll = row_nx == RW'(ROWS_COUNT);
      if (need_scroll) begin
         row_in = RW'(ROWS_COUNT - 1);
         lin_in = AW'(lin_nx - LW'(COLUMNS));
      end else begin
         row_in = row_nx;
         lin_in = AW'(lin_nx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         lin_ff <= '0;
      end else if (cmd.apply_put) begin
         row_ff <= row_in;
         col_ff <= col_in;
         lin_ff <= lin_in;
      end
   end

   // Sweep counter for clearing, scroll copy and fill
   logic [SW-1:0] sweep_ff;
   logic [SW-1:0] sweep_dec;
   logic [SW-1:0] sweep_src;

   assign sweep_dec = sweep_ff - 1'b1;
   assign sweep_src = sweep_ff + SW'(COLUMNS);

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_clr) begin
         sweep_ff <= '0;
      end else if (cmd.clear_wr || cmd.copy_step || cmd.fill_step) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   // Screen store ports
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [tccw_pkg::CELL_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [tccw_pkg::CELL_W-1:0] rd_data_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lin_ff;
      wr_data = {attr_ff, code_ff};
      rd_en   = 1'b0;
      rd_addr = AW'(index_ff);
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff[AW-1:0];
         wr_data = tccw_pkg::BLANK_RESET;
      end else if (cmd.apply_put) begin
         wr_en = printable;
      end else if (cmd.copy_step) begin
         // read one row ahead, write the cell read in the previous step
         wr_en   = sweep_ff != '0;
         wr_addr = sweep_dec[AW-1:0];
         wr_data = rd_data_ff;
         rd_en   = sweep_ff < SW'(CELLS - COLUMNS);
         rd_addr = sweep_src[AW-1:0];
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_dec[AW-1:0];
         wr_data = {attr_ff, tccw_pkg::CODE_SPACE};
      end else if (cmd.issue_read) begin
         rd_en = in_range;
      end
   end

   tccw_ram #(
      .WIDTH (tccw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   // Response registers
   logic [tccw_pkg::CELL_W-1:0] value_ff;
   logic                        scrolled_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         scrolled_ff <= 1'b0;
      end else if (cmd.apply_put) begin
         scrolled_ff <= need_scroll;
      end
      if (cmd.apply_put) begin
         value_ff <= printable ? {attr_ff, code_ff} : '0;
      end else if (cmd.capture_read) begin
         value_ff <= in_range_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_cell_value      = value_ff;
   assign rsp_cursor_position = tccw_pkg::INDEX_W'(lin_ff);
   assign rsp_scrolled        = scrolled_ff;

   // Status to controller
   assign status.clear_last  = sweep_ff == SW'(CELLS - 1);
   assign status.is_read     = type_ff == tccw_pkg::REQ_READ;
   assign status.need_scroll = need_scroll;
   assign status.copy_last   = sweep_ff == SW'(CELLS - COLUMNS);
   assign status.fill_last   = sweep_ff == SW'(CELLS);

endmodule

// ----- dv/text_console_character_writer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_writer_test - console writer testbench
// Sends put and read requests with random idle gaps, and predicts the
// screen store, cursor and scroll flag of each response. Every response is
// compared field by field in arrival order. The color attribute is rewritten
// between traffic phases, including its extremes.
// ----------------------------------------------------------------------------
module text_console_character_writer_test;

   localparam int CODE_W       = tccw_pkg::CODE_W;
   localparam int INDEX_W      = tccw_pkg::INDEX_W;
   localparam int CELL_W       = tccw_pkg::CELL_W;
   localparam int ATTR_W       = tccw_pkg::ATTR_W;
   localparam int COLS         = tccw_pkg::COLUMNS_DEFAULT;
   localparam int SCREEN_ROWS  = tccw_pkg::ROWS_COUNT_DEFAULT;
   localparam int SCREEN_CELLS = COLS * SCREEN_ROWS;

   // Tracks the console contents and the responses still owed by the block
   class console_scoreboard;
      typedef struct packed {
         logic [CELL_W-1:0]  cell_value;
         logic [INDEX_W-1:0] cursor_position;
         logic               scrolled;
      } console_result_type;

      logic [CELL_W-1:0]  screen [SCREEN_CELLS];
      int unsigned        cursor;
      logic [ATTR_W-1:0]  attribute;
      console_result_type awaited_results [$];
      int unsigned        error_count;
      int unsigned        put_count;
      int unsigned        read_count;
      int unsigned        scroll_count;

      function new();
         foreach (screen[i]) screen[i] = tccw_pkg::BLANK_RESET;
         cursor       = 0;
         attribute    = tccw_pkg::ATTR_RESET;
         error_count  = 0;
         put_count    = 0;
         read_count   = 0;
         scroll_count = 0;
      endfunction

      // Apply an accepted request to the console and queue its response
      function void note_request(input logic kind, input logic [CODE_W-1:0] code,
                                 input logic [INDEX_W-1:0] cell_idx);
         console_result_type r;
         int unsigned        i;
         r = '0;
         if (kind == tccw_pkg::REQ_READ) begin
            read_count++;
            if (cell_idx < SCREEN_CELLS) r.cell_value = screen[cell_idx];
         end else begin
            put_count++;
            if (cursor >= SCREEN_CELLS) cursor = 0;
            case (code)
               tccw_pkg::CODE_BACKSPACE: if (cursor % COLS != 0) cursor--;
               tccw_pkg::CODE_LINE_FEED: cursor += COLS;
               tccw_pkg::CODE_RETURN:    cursor -= cursor % COLS;
               default: begin
                  r.cell_value   = {attribute, code};
                  screen[cursor] = r.cell_value;
                  cursor++;
               end
            endcase
            // past the last cell: move everything up a row, blank the bottom row
            if (cursor >= SCREEN_CELLS) begin
               for (i = 0; i < SCREEN_CELLS - COLS; i++) screen[i] = screen[i + COLS];
               for (i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++)
                  screen[i] = {attribute, tccw_pkg::CODE_SPACE};
               cursor    -= COLS;
               r.scrolled = 1'b1;
               scroll_count++;
            end
         end
         r.cursor_position = cursor[INDEX_W-1:0];
         awaited_results.push_back(r);
      endfunction

      // Compare one response against the oldest outstanding request
      function void check_response(input logic [CELL_W-1:0] value,
                                   input logic [INDEX_W-1:0] position,
                                   input logic scr);
         console_result_type want;
         if (awaited_results.size() == 0) begin
            $error("response with no request outstanding: cell_value %h cursor %0d",
                   value, position);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (value !== want.cell_value) begin
            $error("cell_value mismatch: expected %h, actual %h", want.cell_value, value);
            error_count++;
         end
         if (position !== want.cursor_position) begin
            $error("cursor_position mismatch: expected %0d, actual %0d",
                   want.cursor_position, position);
            error_count++;
         end
         if (scr !== want.scrolled) begin
            $error("scrolled mismatch: expected %b, actual %b", want.scrolled, scr);
            error_count++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic                req_type       = tccw_pkg::REQ_PUT;
   logic [CODE_W-1:0]   req_char_code  = '0;
   logic [INDEX_W-1:0]  req_cell_index = '0;
   logic                rsp_valid;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic [INDEX_W-1:0]  rsp_cursor_position;
   logic                rsp_scrolled;
   logic                csr_wr_en      = 1'b0;
   logic [ATTR_W-1:0]   csr_wr_data    = '0;

   console_scoreboard sb = new();
   int unsigned       issued      = 0;
   int unsigned       attr_writes = 0;
   bit                no_idle     = 1'b0;

   text_console_character_writer dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Responses last one cycle and cannot be held off
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_cell_value, rsp_cursor_position, rsp_scrolled);
   end

   // Random idle time before a request, mostly short
   task automatic idle_gap();
      int unsigned n;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 50) n = 0;
      else if (pick < 85)       n = $urandom_range(1, 3);
      else if (pick < 97)       n = $urandom_range(4, 15);
      else                      n = $urandom_range(20, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one request and hold it until the block takes it
   task automatic issue_request(input logic kind, input logic [CODE_W-1:0] code,
                                input logic [INDEX_W-1:0] cell_idx);
      idle_gap();
      start          <= 1'b1;
      req_type       <= kind;
      req_char_code  <= code;
      req_cell_index <= cell_idx;
      do @(posedge clock); while (busy);
      sb.note_request(kind, code, cell_idx);
      issued++;
   endtask

   // Read a cell: near the cursor, anywhere, or at the top end of the range
   task automatic issue_cell_read();
      int unsigned pick;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         idx = INDEX_W'((sb.cursor + SCREEN_CELLS - $urandom_range(1, 100)) % SCREEN_CELLS);
      else if (pick < 90)
         idx = INDEX_W'($urandom);
      else
         idx = INDEX_W'($urandom_range(SCREEN_CELLS - 10, (1 << INDEX_W) - 1));
      issue_request(tccw_pkg::REQ_READ, CODE_W'($urandom), idx);
   endtask

   // Wait until every response is in and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.attribute = value;
      attr_writes++;
   endtask

   // Mostly text lines ended by CR/LF, with reads, backspaces and noise mixed in
   task automatic run_traffic(input int unsigned quota);
      int unsigned done_at;
      int unsigned pick;
      int unsigned len;
      int unsigned k;
      done_at = issued + quota;
      while (issued < done_at) begin
         no_idle = ($urandom_range(0, 9) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 50) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                              : $urandom_range(1, 25);
            for (k = 0; k < len && issued < done_at; k++) begin
               if ($urandom_range(0, 7) == 0) issue_cell_read();
               issue_request(tccw_pkg::REQ_PUT,
                             ($urandom_range(0, 9) == 0) ? CODE_W'($urandom)
                                                         : CODE_W'($urandom_range(32, 126)),
                             INDEX_W'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_RETURN, INDEX_W'($urandom));
               issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_LINE_FEED, INDEX_W'($urandom));
            end else if (pick < 85) begin
               issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_LINE_FEED, INDEX_W'($urandom));
            end
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 4)) issue_cell_read();
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 5))
               issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_BACKSPACE, INDEX_W'($urandom));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6))
               issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_LINE_FEED, INDEX_W'($urandom));
         end else begin
            issue_request(tccw_pkg::REQ_PUT, CODE_W'($urandom), INDEX_W'($urandom));
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [ATTR_W-1:0] attr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // clearing pass after reset keeps busy high
      while (busy) @(posedge clock);

      // Directed: blank store, read range edges, control codes at column 0
      no_idle = 1'b1;
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'd0);
      issue_request(tccw_pkg::REQ_READ, 8'hFF, 11'd1999);
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'd2000);
      issue_request(tccw_pkg::REQ_READ, 8'hFF, 11'h7FF);
      issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_BACKSPACE, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, 8'h00, 11'h7FF);
      issue_request(tccw_pkg::REQ_PUT, 8'hFF, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, 8'h41, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_BACKSPACE, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_RETURN, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_LINE_FEED, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, 8'h7F, 11'd0);
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'd1);
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'd80);
      write_attribute(8'h00);
      issue_request(tccw_pkg::REQ_PUT, 8'h5A, 11'd0);
      write_attribute(8'hFF);
      issue_request(tccw_pkg::REQ_PUT, 8'h7A, 11'd0);
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'd81);

      // Walk down to the bottom row; the final line feeds scroll
      repeat (SCREEN_ROWS) issue_request(tccw_pkg::REQ_PUT, tccw_pkg::CODE_LINE_FEED, 11'd0);
      issue_request(tccw_pkg::REQ_PUT, 8'h42, 11'd0);
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'(SCREEN_CELLS - COLS));
      issue_request(tccw_pkg::REQ_READ, 8'h00, 11'(SCREEN_CELLS - 1));

      // Random traffic phases, each under its own attribute
      for (int p = 0; p < 6; p++) begin
         if (p == 0)      attr = 8'h00;
         else if (p == 1) attr = 8'hFF;
         else if (p == 5) attr = tccw_pkg::ATTR_RESET;
         else             attr = ATTR_W'($urandom);
         write_attribute(attr);
         run_traffic(135);
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests (%0d puts, %0d reads) with %0d scrolls",
               issued, sb.put_count, sb.read_count, sb.scroll_count);
      $display("across %0d attribute settings; %0d mismatches", attr_writes, sb.error_count);
      if (sb.error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Run limit, far above the slowest legal run
   initial begin
      #80ms;
      $display("Verification failed");
      $finish;
   end

endmodule
